// ===== src/rtap_pkg.sv =====
package rtap_pkg;

    localparam int DefMaxTweens = 16;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_STEP   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [31:0] window;
        logic [63:0] from_rect;
        logic [63:0] to_rect;
        logic [31:0] start_time;
        logic [15:0] duration;
    } t_entry;

    localparam int EntryBits = $bits(t_entry);

endpackage

// ===== src/rtap_ram.sv =====
module rtap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rect_tween_animator_top.sv =====
// Rectangle tween animator, ease-out cubic. A transaction is taken when start is high
// and busy is low; busy stays high until the command is done. Start and cancel walk
// the table once, reading and checking each entry in turn. A step runs, per entry, a
// table read, a restoring divider, then the one shared 35x18 multiplier for the
// square, the cube and the four coordinates, and emits one result per entry.
// Each result is marked by o_valid, which is high for exactly one cycle; the
// receiver cannot stall, so it must take every result in the cycle it appears.
module rect_tween_animator_top
    import rtap_pkg::*;
#(
    parameter int MAX_TWEENS = DefMaxTweens
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_window_id,
    input  logic [31:0] i_now_ms,
    input  logic signed [15:0] i_from_x,
    input  logic signed [15:0] i_from_y,
    input  logic [15:0] i_from_width,
    input  logic [15:0] i_from_height,
    input  logic signed [15:0] i_to_x,
    input  logic signed [15:0] i_to_y,
    input  logic [15:0] i_to_width,
    input  logic [15:0] i_to_height,
    input  logic [15:0] i_duration_ms,
    output logic        o_valid,
    output logic [31:0] o_out_window_id,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic [15:0] o_out_width,
    output logic [15:0] o_out_height,
    output logic        o_finished,
    output logic        o_last,
    output logic        o_still_active
);

    localparam int AW = (MAX_TWEENS > 1) ? $clog2(MAX_TWEENS) : 1;
    localparam int CW = $clog2(MAX_TWEENS + 1);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_RD   = 11'b000_0000_0010,
        S_CHK  = 11'b000_0000_0100,
        S_APP  = 11'b000_0000_1000,
        S_DIV  = 11'b000_0001_0000,
        S_SQ   = 11'b000_0010_0000,
        S_CU   = 11'b000_0100_0000,
        S_EA   = 11'b000_1000_0000,
        S_BL   = 11'b001_0000_0000,
        S_BA   = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } t_state;

    t_state      r_state;
    logic [1:0]  r_cmd;
    logic [31:0] r_id;
    logic [31:0] r_now;
    t_entry      r_new;
    t_entry      r_ent;
    logic [CW-1:0] r_n, r_i, r_dst;
    logic        r_fin;
    logic [15:0] r_rem, r_q;
    logic [3:0]  r_dc;
    logic [1:0]  r_k;
    logic [16:0] r_inv, r_eased;
    logic signed [52:0] r_prod;
    logic [15:0] r_res [4];
    logic        r_valid, r_last, r_still;

    t_entry      rdata, wdata;
    logic        we;
    logic [AW-1:0] waddr;

    logic signed [34:0] m_a;
    logic signed [17:0] m_b;

    logic [31:0] elapsed;
    logic [16:0] rem2, dur17;
    logic        ge;
    logic [15:0] q_next;
    logic [52:0] cube_sum;
    logic [15:0] f16, t16;
    logic signed [16:0] f17, t17, diff;
    logic [52:0] mag, rnd;
    logic [16:0] rq;
    logic [16:0] res17;

    rtap_ram #(.WIDTH(EntryBits), .DEPTH(MAX_TWEENS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (rdata)
    );

    assign busy = (r_state != S_IDLE);

    always_comb begin
        we    = 1'b0;
        waddr = r_dst[AW-1:0];
        wdata = rdata;
        case (r_state)
            S_CHK: we = (r_cmd != CMD_STEP) && (rdata.window != r_id);
            S_APP: begin
                we    = (r_dst < CW'(MAX_TWEENS));
                wdata = r_new;
            end
            S_OUT: begin
                we    = !r_fin;
                wdata = r_ent;
            end
            default: we = 1'b0;
        endcase
    end

    assign elapsed  = r_now - rdata.start_time;
    assign dur17    = {1'b0, r_ent.duration};
    assign rem2     = {r_rem, 1'b0};
    assign ge       = (rem2 >= dur17);
    assign q_next   = {r_q[14:0], ge};
    assign cube_sum = r_prod + 53'h0_0000_8000_0000;

    always_comb begin
        f16 = r_ent.from_rect[r_k*16 +: 16];
        t16 = r_ent.to_rect[r_k*16 +: 16];
        if (r_k[1]) begin
            f17 = {1'b0, f16};
            t17 = {1'b0, t16};
        end else begin
            f17 = {f16[15], f16};
            t17 = {t16[15], t16};
        end
        diff = t17 - f17;
        mag  = r_prod[52] ? 53'(-r_prod) : r_prod;
        rnd  = mag + 53'd32768;
        rq   = rnd[32:16];
        res17 = r_prod[52] ? 17'(f17 - rq) : 17'(f17 + rq);
    end

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_SQ: begin
                m_a = {18'b0, r_inv};
                m_b = {1'b0, r_inv};
            end
            S_CU: begin
                m_a = r_prod[34:0];
                m_b = {1'b0, r_inv};
            end
            S_BL: begin
                m_a = {{18{diff[16]}}, diff};
                m_b = {1'b0, r_eased};
            end
            default: m_a = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= m_a * m_b;
        r_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd            <= i_cmd;
                        r_id             <= i_window_id;
                        r_now            <= i_now_ms;
                        r_new.window     <= i_window_id;
                        r_new.from_rect  <= {i_from_height, i_from_width, i_from_y, i_from_x};
                        r_new.to_rect    <= {i_to_height, i_to_width, i_to_y, i_to_x};
                        r_new.start_time <= i_now_ms;
                        r_new.duration   <= (i_duration_ms == 16'd0) ? 16'd1 : i_duration_ms;
                        r_i              <= '0;
                        r_dst            <= '0;
                        case (i_cmd)
                            CMD_START:  r_state <= (r_n == '0) ? S_APP : S_RD;
                            CMD_CANCEL: r_state <= (r_n == '0) ? S_IDLE : S_RD;
                            CMD_STEP:   r_state <= (r_n == '0) ? S_IDLE : S_RD;
                            default:    r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    r_ent <= rdata;
                    if (r_cmd == CMD_STEP) begin
                        r_fin   <= (elapsed >= {16'b0, rdata.duration});
                        r_rem   <= elapsed[15:0];
                        r_q     <= '0;
                        r_dc    <= '0;
                        r_state <= S_DIV;
                    end else begin
                        if (rdata.window != r_id) begin
                            r_dst <= r_dst + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                        if (r_i + 1'b1 == r_n) begin
                            if (r_cmd == CMD_START) begin
                                r_state <= S_APP;
                            end else begin
                                r_n     <= (rdata.window != r_id) ? CW'(r_dst + 1'b1) : r_dst;
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_APP: begin
                    r_n     <= (r_dst < CW'(MAX_TWEENS)) ? CW'(r_dst + 1'b1) : r_dst;
                    r_state <= S_IDLE;
                end
                S_DIV: begin
                    r_rem <= ge ? 16'(rem2 - dur17) : rem2[15:0];
                    r_q   <= q_next;
                    r_dc  <= r_dc + 4'd1;
                    if (r_dc == 4'd15) begin
                        r_inv   <= r_fin ? 17'd0 : 17'(17'h10000 - {1'b0, q_next});
                        r_state <= S_SQ;
                    end
                end
                S_SQ: r_state <= S_CU;
                S_CU: r_state <= S_EA;
                S_EA: begin
                    r_eased <= 17'(17'h10000 - cube_sum[48:32]);
                    r_k     <= '0;
                    r_state <= S_BL;
                end
                S_BL: r_state <= S_BA;
                S_BA: begin
                    r_res[r_k] <= res17[15:0];
                    r_k        <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_valid <= 1'b1;
                        r_last  <= (r_i == CW'(r_n - 1'b1));
                        r_still <= (r_dst != '0) || !r_fin;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_BL;
                    end
                end
                S_OUT: begin
                    if (!r_fin) begin
                        r_dst <= r_dst + 1'b1;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i + 1'b1 == r_n) begin
                        r_n     <= r_fin ? r_dst : CW'(r_dst + 1'b1);
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_out_window_id = r_ent.window;
    assign o_out_x         = r_res[0];
    assign o_out_y         = r_res[1];
    assign o_out_width     = r_res[2];
    assign o_out_height    = r_res[3];
    assign o_finished      = r_fin;
    assign o_last          = r_last;
    assign o_still_active  = r_last & r_still;

endmodule
